// ===== src/rle_dec_pkg.sv =====
// shared types and constants for the run-length record decoder
package rle_dec_pkg;

  localparam int BYTE_W      = 8;
  localparam int OUT_WORD_W  = 64;
  localparam int REC_BYTES_W = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 8;

  localparam logic [REC_BYTES_W-1:0] REC_BYTES_RST = 11'h2A8;
  localparam logic                   CFG_IDX_RECORD_BYTES = 1'b0;

  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  typedef enum logic [1:0] {
    PH_LIT,
    PH_COUNT,
    PH_POST,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PUT,
    ST_PAD,
    ST_TAIL,
    ST_END
  } state_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0] word;
    logic                  status;
    logic                  record_last;
  } res_t;

  typedef struct packed {
    logic push;
    logic close;
  } outq_ctl_t;

  typedef struct packed {
    logic can_push;
    logic close_ok;
    logic hold_empty;
  } outq_sts_t;

endpackage

// ===== src/rle_dec_if.sv =====
// handshake channels for source bytes and decoded results
interface rle_dec_in_if import rle_dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface rle_dec_out_if import rle_dec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_WORD_W-1:0] out_word;
  logic                  status;
  logic                  record_last;
  logic                  burst_last;

  modport source (output valid, out_word, status, record_last, burst_last, input ready);
  modport sink (input valid, out_word, status, record_last, burst_last, output ready);
endinterface

// ===== src/rle_dec_outq.sv =====
// result hold stage and output register, marks the last result of each burst
module rle_dec_outq import rle_dec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  outq_ctl_t            ctl,
  input  res_t                 res,
  output outq_sts_t            sts,
  rle_dec_out_if.source        out_chan
);

  logic hold_v_r, hold_v_nxt;
  res_t hold_r, hold_nxt;
  logic out_v_r, out_v_nxt;
  res_t out_r, out_nxt;
  logic burst_r, burst_nxt;
  logic out_free;
  logic move;

  assign out_free = !out_v_r || out_chan.ready;
  assign move     = hold_v_r && out_free && (ctl.push || ctl.close);

  assign sts.can_push   = !hold_v_r || out_free;
  assign sts.close_ok   = !hold_v_r || out_free;
  assign sts.hold_empty = !hold_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    burst_nxt  = burst_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
    if (move) begin
      out_v_nxt  = 1'b1;
      out_nxt    = hold_r;
      burst_nxt  = ctl.close;
      hold_v_nxt = 1'b0;
    end
    if (ctl.push) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
    burst_r <= burst_nxt;
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.out_word    = out_r.word;
  assign out_chan.status      = out_r.status;
  assign out_chan.record_last = out_r.record_last;
  assign out_chan.burst_last  = burst_r;

endmodule

// ===== src/rle_repeat_escape_decoder.sv =====
// top level: byte-serial run-length record decoder with apb length register
// a result waits in the hold stage until the next result or the end of its byte; a new source
//   byte is taken only once the previous one is fully decoded
// the word shift register takes one decoded byte per cycle while a completed word is not waiting
//   for room in the hold stage; zero pad bytes fill a final partial word
// reset: synchronous active-low rst_n clears the record state, record_bytes goes to 680
module rle_repeat_escape_decoder import rle_dec_pkg::*; #(
  parameter int MAX_RECORD_BYTES = 1024,
  parameter int WORD_BYTES       = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rle_dec_in_if.sink            in_chan,
  rle_dec_out_if.source         out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CW = $clog2(MAX_RECORD_BYTES + 1);
  localparam int LW = (CW > REC_BYTES_W) ? CW : REC_BYTES_W;
  localparam int PW = WORD_BYTES * BYTE_W;
  localparam int SW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_RECORD_BYTES);

  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [BYTE_W-1:0]      pb_r, pb_nxt;
  logic                   pv_r, pv_nxt;
  logic [CW-1:0]          bw_r, bw_nxt;
  logic [PW-1:0]          pend_r, pend_nxt;
  logic [SW-1:0]          slot_r, slot_nxt;
  logic [BYTE_W-1:0]      byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic                   err_r, err_nxt;
  logic                   early_r, early_nxt;
  logic                   marker_r, marker_nxt;
  logic [REC_BYTES_W-1:0] rec_bytes_r;

  outq_ctl_t ctl;
  outq_sts_t sts;
  res_t      res;

  logic [LW-1:0]     rec_ext;
  logic [LW-1:0]     len_eff;
  logic [LW-1:0]     bw_ext;
  logic              full;
  logic              full_after;
  logic              slot_full;
  logic              can_emit;
  logic              in_xfer;
  logic              cfg_wr;
  logic [BYTE_W-1:0] put_src;
  logic [PW-1:0]     pend_sh;
  logic [PW-1:0]     pend_pad;
  logic [SW-1:0]     slot_inc;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_bytes_r <= REC_BYTES_RST;
    end else if (cfg_wr && cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_RECORD_BYTES) begin
      rec_bytes_r <= cfg_pwdata[REC_BYTES_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_RECORD_BYTES) ?
                      CFG_DATA_W'(rec_bytes_r) : '0;

  // effective record length and byte position
  assign rec_ext    = LW'(rec_bytes_r);
  assign len_eff    = (rec_bytes_r == '0) ? LW'(1) : ((rec_ext > MAX_L) ? MAX_L : rec_ext);
  assign bw_ext     = LW'(bw_r);
  assign full       = bw_ext >= len_eff;
  assign full_after = (bw_ext + LW'(1)) >= len_eff;
  assign slot_full  = slot_r == SW'(WORD_BYTES - 1);
  assign slot_inc   = slot_full ? '0 : SW'(slot_r + 1'b1);
  assign can_emit   = sts.can_push;
  assign in_xfer    = in_chan.valid && in_chan.ready;

  // word shift register, newest byte enters at the top
  assign put_src  = (phase_r == PH_COUNT) ? pb_r : byte_r;
  assign pend_sh  = PW'({put_src, pend_r} >> BYTE_W);
  assign pend_pad = PW'({{BYTE_W{1'b0}}, pend_r} >> BYTE_W);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (phase_r != PH_DONE && full) begin
          if (slot_r != '0) begin
            state_nxt = ST_PAD;
          end else if (can_emit) begin
            state_nxt = ST_TAIL;
          end
        end else if (phase_r == PH_DONE) begin
          state_nxt = ST_TAIL;
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (cnt_r != '0 && !full) begin
          if (!slot_full && full_after) begin
            state_nxt = ST_PAD;
          end
        end else begin
          state_nxt = ST_TAIL;
        end
      end
      ST_PAD: begin
        if (slot_full && can_emit) begin
          state_nxt = early_r ? ST_TAIL : ST_PUT;
        end
      end
      ST_TAIL: begin
        if (!err_r || can_emit) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (sts.close_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt  = phase_r;
    pb_nxt     = pb_r;
    pv_nxt     = pv_r;
    bw_nxt     = bw_r;
    pend_nxt   = pend_r;
    slot_nxt   = slot_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    early_nxt  = early_r;
    marker_nxt = marker_r;
    ctl        = '0;
    res        = '0;
    in_chan.ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_nxt = in_chan.in_byte;
          last_nxt = in_chan.in_last;
        end
      end
      ST_CHECK: begin
        err_nxt   = 1'b0;
        early_nxt = 1'b0;
        if (phase_r != PH_DONE && full) begin
          // length lowered under a partly built record
          if (slot_r != '0) begin
            early_nxt = 1'b1;
          end else if (can_emit) begin
            ctl.push        = 1'b1;
            res.word        = OUT_WORD_W'(pend_r);
            res.status      = STATUS_DATA;
            res.record_last = 1'b1;
            pend_nxt        = '0;
            phase_nxt       = PH_DONE;
          end
        end else begin
          case (phase_r)
            PH_LIT: begin
              marker_nxt = pv_r && (byte_r == pb_r);
              pb_nxt     = byte_r;
              pv_nxt     = 1'b1;
              cnt_nxt    = COUNT_W'(1);
            end
            PH_COUNT: begin
              cnt_nxt = byte_r;
            end
            PH_POST: begin
              pb_nxt  = byte_r;
              cnt_nxt = COUNT_W'(1);
            end
            default: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end
      ST_PUT: begin
        if (cnt_r != '0 && !full) begin
          if (!slot_full || can_emit) begin
            pend_nxt = slot_full ? '0 : pend_sh;
            bw_nxt   = CW'(bw_r + 1'b1);
            slot_nxt = slot_inc;
            cnt_nxt  = COUNT_W'(cnt_r - 1'b1);
            if (slot_full) begin
              ctl.push        = 1'b1;
              res.word        = OUT_WORD_W'(pend_sh);
              res.status      = STATUS_DATA;
              res.record_last = full_after;
            end
          end
        end else begin
          case (phase_r)
            PH_LIT: begin
              if (marker_r) begin
                if (last_r) begin
                  err_nxt = 1'b1;
                end else begin
                  phase_nxt = full ? PH_DONE : PH_COUNT;
                end
              end else if (full) begin
                phase_nxt = PH_DONE;
              end else if (last_r) begin
                err_nxt = 1'b1;
              end
            end
            PH_COUNT: begin
              if (full) begin
                phase_nxt = PH_DONE;
              end else if (last_r) begin
                err_nxt = 1'b1;
              end else begin
                phase_nxt = PH_POST;
              end
            end
            PH_POST: begin
              if (full) begin
                phase_nxt = PH_DONE;
              end else if (last_r) begin
                err_nxt = 1'b1;
              end else begin
                phase_nxt = PH_LIT;
              end
            end
            default: begin
              err_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_PAD: begin
        if (!slot_full || can_emit) begin
          pend_nxt = slot_full ? '0 : pend_pad;
          slot_nxt = slot_inc;
          if (slot_full) begin
            ctl.push        = 1'b1;
            res.word        = OUT_WORD_W'(pend_pad);
            res.status      = STATUS_DATA;
            res.record_last = 1'b1;
            if (early_r) begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
      ST_TAIL: begin
        if (!err_r || can_emit) begin
          if (err_r) begin
            ctl.push        = 1'b1;
            res.word        = '0;
            res.status      = STATUS_TRUNC;
            res.record_last = 1'b1;
          end
          if (last_r) begin
            phase_nxt = PH_LIT;
            pb_nxt    = '0;
            pv_nxt    = 1'b0;
            bw_nxt    = '0;
            pend_nxt  = '0;
            slot_nxt  = '0;
          end
        end
      end
      ST_END: begin
        ctl.close = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_LIT;
      pb_r     <= '0;
      pv_r     <= 1'b0;
      bw_r     <= '0;
      pend_r   <= '0;
      slot_r   <= '0;
      err_r    <= 1'b0;
      early_r  <= 1'b0;
      marker_r <= 1'b0;
      last_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      pb_r     <= pb_nxt;
      pv_r     <= pv_nxt;
      bw_r     <= bw_nxt;
      pend_r   <= pend_nxt;
      slot_r   <= slot_nxt;
      err_r    <= err_nxt;
      early_r  <= early_nxt;
      marker_r <= marker_nxt;
      last_r   <= last_nxt;
      cnt_r    <= cnt_nxt;
    end
    byte_r <= byte_nxt;
  end

  rle_dec_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .res      (res),
    .sts      (sts),
    .out_chan (out_chan)
  );

  // no result may be left waiting once the block is ready for a new byte
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> sts.hold_empty)
    else $error("result left in hold stage while idle");

  // error results carry a zero word and close the record
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status |-> out_chan.out_word == '0 && out_chan.record_last)
    else $error("malformed truncation result");

  // zero padding only happens on a complete record
  a_pad_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PAD |-> full && phase_r != PH_DONE)
    else $error("padding before record complete");

  // a byte transfer always starts a decode pass
  a_xfer_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_CHECK)
    else $error("byte transfer not followed by decode");

endmodule
